/* hw/rtl/double_ended_queue_core_defines.svh */
// Assertion macros used by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/deq_pkg.sv */
// Types, constants and helper functions of the double-ended queue core.
`timescale 1ns / 1ps
package deq_pkg;

    // Storage depth, 2 to 64 words.
    localparam int CAPACITY = 16;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Command codes.
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_DUMP       = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } deq_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic               last;
    } deq_result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP_OUT,
        S_DUMP
    } deq_state_t;

    typedef enum logic [1:0] {
        RD_FRONT,
        RD_BACK,
        RD_DUMP
    } deq_rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        capture;
        logic        push_front;
        logic        push_back;
        logic        pop_front;
        logic        pop_back;
        logic        rd_en;
        deq_rd_sel_t rd_sel;
        logic        emit;
        logic [1:0]  emit_status;
        logic        emit_data;
        logic        emit_last;
    } deq_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] cmd;
        logic       full;
        logic       empty;
        logic       dump_last;
    } deq_stat_t;

    // Ring slot at a given offset from a base slot; base < CAPACITY, off <= CAPACITY.
    function automatic ptr_t slot_add(ptr_t base, cnt_t off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(CAPACITY)) begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

/* hw/rtl/double_ended_queue_core.sv */
// Top level of the double-ended queue core.
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit words held in a ring of CAPACITY
// entries. Issue a command word by raising start while busy is low; the word
// is taken at that clock edge. Commands: push front, push back, pop front, pop
// back, dump. Each push or pop returns one result word; a dump returns every
// stored word from front to back on consecutive cycles, last set on the final
// one, or a single empty status when the queue holds nothing. A push into a
// full queue returns status full and leaves the queue untouched; unused
// command codes return nothing. Results appear on res for exactly one cycle,
// marked by res_valid, and cannot be held off: sample them when they come.
// Pushes, and any command that fails, give their result word straight from the
// execute state; a successful pop or a dump first reads the storage RAM into a
// register, and a dump then streams one word a cycle. The controller runs one
// command at a time, so busy stays high until the final result word is on its
// way out. The storage needs no clearing after reset: no entry is read before
// it is written.
module double_ended_queue_core
    import deq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  deq_item_t   item,
    output logic        res_valid,
    output deq_result_t res
);

    deq_ctl_t  ctl;
    deq_stat_t stat;

    // Sequence each command: decode, update pointers, steer reads and results.
    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Hold the ring storage, front pointer, occupancy and result register.
    deq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .ctl       (ctl),
        .stat      (stat),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

/* hw/rtl/deq_ctrl.sv */
// Controller state machine of the double-ended queue core.
`timescale 1ns / 1ps
module deq_ctrl
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  deq_stat_t stat,
    output deq_ctl_t  ctl,
    output logic      busy
);

    deq_state_t state_reg;
    deq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.rd_sel = RD_FRONT;
        busy       = 1'b1;
        unique case (state_reg)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    ctl.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
                unique case (stat.cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                        ctl.emit      = 1'b1;
                        ctl.emit_last = 1'b1;
                        if (stat.full) begin
                            ctl.emit_status = ST_FULL;
                        end else begin
                            ctl.emit_status = ST_OK;
                            ctl.push_front  = (stat.cmd == CMD_PUSH_FRONT);
                            ctl.push_back   = (stat.cmd == CMD_PUSH_BACK);
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK: begin
                        if (stat.empty) begin
                            ctl.emit        = 1'b1;
                            ctl.emit_status = ST_EMPTY;
                            ctl.emit_last   = 1'b1;
                        end else begin
                            ctl.rd_en     = 1'b1;
                            ctl.rd_sel    = (stat.cmd == CMD_POP_FRONT) ? RD_FRONT : RD_BACK;
                            ctl.pop_front = (stat.cmd == CMD_POP_FRONT);
                            ctl.pop_back  = (stat.cmd == CMD_POP_BACK);
                            state_next    = S_POP_OUT;
                        end
                    end
                    CMD_DUMP: begin
                        if (stat.empty) begin
                            ctl.emit        = 1'b1;
                            ctl.emit_status = ST_EMPTY;
                            ctl.emit_last   = 1'b1;
                        end else begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = RD_DUMP;
                            state_next = S_DUMP;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POP_OUT: begin
                ctl.emit        = 1'b1;
                ctl.emit_status = ST_OK;
                ctl.emit_data   = 1'b1;
                ctl.emit_last   = 1'b1;
                state_next      = S_IDLE;
            end
            S_DUMP: begin
                ctl.emit        = 1'b1;
                ctl.emit_status = ST_OK;
                ctl.emit_data   = 1'b1;
                ctl.emit_last   = stat.dump_last;
                if (stat.dump_last) begin
                    state_next = S_IDLE;
                end else begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_DUMP;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/deq_dp.sv */
// Datapath of the double-ended queue core: ring storage, pointers, result register.
`timescale 1ns / 1ps
module deq_dp
    import deq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  deq_item_t   item,
    input  deq_ctl_t    ctl,
    output deq_stat_t   stat,
    output logic        res_valid,
    output deq_result_t res
);

    logic signed [31:0] mem [CAPACITY];

    logic [2:0]         cmd_reg;
    logic signed [31:0] value_reg;
    ptr_t               front_reg;
    ptr_t               front_next;
    cnt_t               occ_reg;
    cnt_t               occ_next;
    cnt_t               dump_idx_reg;
    logic               dump_last_reg;
    logic signed [31:0] rd_data_reg;
    logic               res_valid_reg;
    deq_result_t        res_reg;

    ptr_t               front_dec;
    ptr_t               wr_addr;
    ptr_t               rd_addr;
    logic               wr_en;
    logic               dump_step;

    assign front_dec = (front_reg == '0) ? PTR_W'(CAPACITY - 1) : front_reg - 1'b1;
    assign wr_en     = ctl.push_front | ctl.push_back;
    assign wr_addr   = ctl.push_front ? front_dec : slot_add(front_reg, occ_reg);
    assign dump_step = ctl.rd_en && (ctl.rd_sel == RD_DUMP);

    always_comb begin
        unique case (ctl.rd_sel)
            RD_FRONT: rd_addr = front_reg;
            RD_BACK:  rd_addr = slot_add(front_reg, occ_reg - 1'b1);
            RD_DUMP:  rd_addr = slot_add(front_reg, dump_idx_reg);
            default:  rd_addr = front_reg;
        endcase
    end

    always_comb begin
        front_next = front_reg;
        occ_next   = occ_reg;
        if (ctl.push_front) begin
            front_next = front_dec;
            occ_next   = occ_reg + 1'b1;
        end else if (ctl.push_back) begin
            occ_next = occ_reg + 1'b1;
        end else if (ctl.pop_front) begin
            front_next = slot_add(front_reg, CNT_W'(1));
            occ_next   = occ_reg - 1'b1;
        end else if (ctl.pop_back) begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            front_reg     <= '0;
            occ_reg       <= '0;
            dump_idx_reg  <= '0;
            dump_last_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            res_valid_reg <= ctl.emit;
            if (ctl.capture) begin
                dump_idx_reg  <= '0;
                dump_last_reg <= 1'b0;
            end else if (dump_step) begin
                dump_idx_reg  <= dump_idx_reg + 1'b1;
                dump_last_reg <= ((CNT_W + 1)'(dump_idx_reg) + 1'b1) == (CNT_W + 1)'(occ_reg);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (ctl.capture) begin
            cmd_reg   <= item.cmd;
            value_reg <= item.value;
        end
        if (ctl.emit) begin
            res_reg.status   <= ctl.emit_status;
            res_reg.data_out <= ctl.emit_data ? rd_data_reg : 32'sd0;
            res_reg.last     <= ctl.emit_last;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= value_reg;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.full      = (occ_reg == CNT_W'(CAPACITY));
    assign stat.empty     = (occ_reg == '0);
    assign stat.dump_last = dump_last_reg;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* hw/rtl/deq_checker.sv */
// Port-level checker of the double-ended queue core and its bind.
`timescale 1ns / 1ps
`include "double_ended_queue_core_defines.svh"
module deq_checker
    import deq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        res_valid,
    input deq_result_t res
);

    `DEQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `DEQ_ASSERT_NOW(a_fail_zero, res_valid && (res.status != ST_OK),
        (res.data_out == 32'sd0) && res.last, "failed result not zero or not last")
    `DEQ_ASSERT_NOW(a_last_idle, res_valid && res.last, !busy, "busy still high on final result")
    `DEQ_ASSERT_NEXT(a_dump_stream, res_valid && !res.last, res_valid,
        "dump stream broke before last word")

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench of the double-ended queue core.
`timescale 1ns / 1ps
module testbench;
    import deq_pkg::*;

    // Stop the run here; the slowest legal run needs well under a tenth of it.
    localparam int CYCLE_LIMIT = 200000;
    // Let stray result words show up after the last expected one.
    localparam int TAIL_CYCLES = CAPACITY + 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    deq_item_t   item;
    logic        res_valid;
    deq_result_t res;

    // Shadow copy of the ring contents, front slot and fill level.
    logic signed [31:0] shadow_ring [CAPACITY];
    int                 shadow_front;
    int                 shadow_count;

    // Result words still owed by the core, oldest first.
    deq_result_t owed_words [$];

    int  error_count;
    int  cycle_count;
    // Insert random gaps before each command word while set.
    bit  gaps_on;

    double_ended_queue_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Advance the shadow deque by one command word and queue the result words
    // that the core must give back for it. Unused codes give nothing.
    function automatic void update_shadow_deque(input deq_item_t w);
        deq_result_t r;
        int          i;
        r        = '0;
        r.last   = 1'b1;
        r.status = ST_OK;
        case (w.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (shadow_count >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else if (w.cmd == CMD_PUSH_FRONT)
                begin
                    shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
                    shadow_ring[shadow_front] = w.value;
                    shadow_count++;
                end
                else
                begin
                    shadow_ring[(shadow_front + shadow_count) % CAPACITY] = w.value;
                    shadow_count++;
                end
                owed_words.push_back(r);
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (w.cmd == CMD_POP_FRONT)
                begin
                    r.data_out   = shadow_ring[shadow_front];
                    shadow_front = (shadow_front + 1) % CAPACITY;
                    shadow_count--;
                end
                else
                begin
                    r.data_out = shadow_ring[(shadow_front + shadow_count - 1) % CAPACITY];
                    shadow_count--;
                end
                owed_words.push_back(r);
            end
            CMD_DUMP:
            begin
                if (shadow_count == 0)
                begin
                    r.status = ST_EMPTY;
                    owed_words.push_back(r);
                end
                else
                begin
                    // Stream front to back; flag only the final word.
                    for (i = 0; i < shadow_count; i++)
                    begin
                        r.data_out = shadow_ring[(shadow_front + i) % CAPACITY];
                        r.last     = (i == shadow_count - 1);
                        owed_words.push_back(r);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Mostly random values, with the sign extremes and their neighbors mixed in.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(15))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -32'sd1;
            default: return $signed($urandom);
        endcase
    endfunction

    // Present one command word and hold it until the core takes it. Leave start
    // high on return so that a following word can go out with no gap.
    task automatic send_word(input logic [2:0] c, input logic signed [31:0] v);
        deq_item_t w;
        deq_item_t junk;
        w.cmd      = c;
        w.value    = v;
        junk.cmd   = 3'($urandom);
        junk.value = $signed($urandom);
        if (gaps_on && $urandom_range(99) < 35)
        begin
            start <= 1'b0;
            item  <= junk;
            @(posedge clk);
            while ($urandom_range(99) < 35)
            begin
                @(posedge clk);
            end
        end
        start <= 1'b1;
        item  <= w;
        // Sample busy as it stood just before the edge: low means taken.
        do
        begin
            @(posedge clk);
        end
        while (busy);
        update_shadow_deque(w);
    endtask

    // Drop start and hold off until every owed result word has come back.
    task automatic wait_until_drained();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (owed_words.size() != 0 || busy);
    endtask

    // Empty-queue corner cases and unused command codes.
    task automatic test_empty_queue();
        send_word(CMD_POP_FRONT, pick_value());
        send_word(CMD_POP_BACK, pick_value());
        send_word(CMD_DUMP, pick_value());
        send_word(3'd5, 32'sh7FFF_FFFF);
        send_word(3'd6, 32'sh8000_0000);
        send_word(3'd7, -32'sd1);
        send_word(CMD_DUMP, '0);
    endtask

    // Push the value extremes at both ends, dump, then pop from both ends.
    task automatic test_push_pop_extremes();
        send_word(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
        send_word(CMD_PUSH_FRONT, 32'sh8000_0000);
        send_word(CMD_PUSH_BACK, '0);
        send_word(CMD_PUSH_FRONT, -32'sd1);
        send_word(CMD_DUMP, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_FRONT, '0);
    endtask

    // Fill to the brim from both ends, push into the full queue, dump it all,
    // then empty it again so the ring wraps around in both directions.
    task automatic test_full_queue();
        while (shadow_count < CAPACITY)
        begin
            send_word($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        end
        send_word(CMD_PUSH_FRONT, pick_value());
        send_word(CMD_PUSH_BACK, pick_value());
        send_word(CMD_DUMP, pick_value());
        while (shadow_count > 0)
        begin
            send_word($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
        end
        send_word(CMD_DUMP, pick_value());
    endtask

    // Random traffic that swings between filling and draining phases, so the
    // queue visits empty and full many times with the ring wrapped anywhere.
    task automatic test_random_traffic(input int n_words);
        int  sent;
        int  roll;
        bit  filling;
        sent    = 0;
        filling = 1'b1;
        while (sent < n_words)
        begin
            // Run a long stretch back to back with no gaps at all.
            gaps_on = !(sent >= 100 && sent < 170);
            if (sent == 200)
            begin
                wait_until_drained();
            end
            if (shadow_count == CAPACITY)
            begin
                filling = $urandom_range(3) == 0;
            end
            else if (shadow_count == 0)
            begin
                filling = $urandom_range(3) != 0;
            end
            else if ($urandom_range(19) == 0)
            begin
                filling = !filling;
            end
            roll = $urandom_range(99);
            if (roll < 3)
            begin
                // Unused codes change nothing; leave them out of the count.
                send_word(3'($urandom_range(7, 5)), pick_value());
            end
            else
            begin
                if (roll < 11)
                begin
                    send_word(CMD_DUMP, pick_value());
                end
                else if ((roll < 80) == filling)
                begin
                    send_word($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                              pick_value());
                end
                else
                begin
                    send_word($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK,
                              pick_value());
                end
                sent++;
            end
        end
    endtask

    // Match each result word against the oldest owed word, field by field.
    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n && res_valid)
        begin
            if (owed_words.size() == 0)
            begin
                $error("unexpected result word: status %0d data_out %0d last %0b",
                       res.status, res.data_out, res.last);
                error_count++;
            end
            else
            begin
                want = owed_words.pop_front();
                if (res.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res.status);
                    error_count++;
                end
                if (res.data_out !== want.data_out)
                begin
                    $error("data_out: expected %0d, got %0d", want.data_out, res.data_out);
                    error_count++;
                end
                if (res.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, res.last);
                    error_count++;
                end
            end
        end
    end

    // Guard against a hang: count cycles and give up at the limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        error_count  = 0;
        cycle_count  = 0;
        shadow_front = 0;
        shadow_count = 0;
        gaps_on      = 1'b1;
        rst_n <= 1'b0;
        start <= 1'b0;
        item  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_push_pop_extremes();
        wait_until_drained();
        test_full_queue();
        test_random_traffic(250);

        // Drain, then hold a while longer to catch any extra result words.
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
